@@ rtl/nie_pkg.sv @@
// Shared types, codes and the saturating add/subtract helper of the Newton interpolation evaluator.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
package nie_pkg;

	localparam int NIE_MAX_POINTS = 16;
	localparam int NIE_FRAC_BITS  = 16;

	typedef struct packed {
		logic               action;
		logic               first_point;
		logic signed [31:0] point_x;
		logic signed [31:0] point_y;
		logic signed [31:0] query_point;
	} req_t;

	typedef struct packed {
		logic signed [31:0] value;
		logic [2:0]         status;
	} res_t;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_NO_POINTS = 3'd1,
		ST_REPEATED  = 3'd2,
		ST_DROPPED   = 3'd3,
		ST_SATURATED = 3'd4
	} status_t;

	typedef enum logic [1:0] {
		OP_LOAD    = 2'd0,
		OP_RESTART = 2'd1,
		OP_EVAL    = 2'd2
	} op_t;

	typedef struct packed {
		op_t                op;
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic signed [31:0] t;
	} cmd_t;

	typedef struct packed {
		logic valid;
		logic take;
	} qctl_t;

	typedef enum logic [4:0] {
		S_IDLE, S_LOAD,
		S_BLD_RDI, S_BLD_RD0, S_BLD_C0, S_BLD_RDJ, S_BLD_D, S_BLD_P, S_BLD_PC, S_BLD_C,
		S_BLD_DIV, S_BLD_WAIT,
		S_EV_CHK, S_EV_RDN, S_EV_R0, S_EV_RD, S_EV_MUL, S_EV_ACC, S_EV_OUT
	} state_t;

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;

	// Saturating add or subtract; bit 32 of the result flags saturation.
	function automatic logic [32:0] sat_addsub(logic signed [31:0] a, logic signed [31:0] b,
		logic do_sub);
		logic signed [32:0] s;
		logic [32:0] r;
		s = do_sub ? (33'(a) - 33'(b)) : (33'(a) + 33'(b));
		if (s[32] != s[31]) begin
			r = {1'b1, (s[32] ? Q_MIN : Q_MAX)};
		end else begin
			r = {1'b0, s[31:0]};
		end
		return r;
	endfunction

endpackage

@@ rtl/newton_interp_eval.sv @@
// Top level of the Newton divided-difference interpolation evaluator.
// Depends on nie_pkg, nie_front and nie_back (which uses nie_div).
`timescale 1ns / 1ps
// Sample points are loaded one request at a time (a load marked first_point starts a new
// set) and an evaluate request returns the Newton polynomial of the set at its query
// point, in signed fixed point with FRAC_BITS fraction bits; loads produce no result. The
// front end classifies requests into a two-entry queue, so up to two requests are taken
// while the back end is busy, and a finished result waits in an output register without
// holding up the next request. A load writes the point and, when the set has already
// been evaluated, also updates the coefficient of the new point; the serial divider, one
// quotient bit per cycle, dominates each coefficient. The first evaluate after new
// points builds all coefficients once, and every evaluate then walks the stored
// coefficients in Horner order, reading, multiplying and accumulating for each point,
// unless the set is empty or holds a repeated x.
// The point and coefficient stores hold nothing meaningful after reset until loaded.
module newton_interp_eval import nie_pkg::*; #(
	parameter int MAX_POINTS = NIE_MAX_POINTS,
	parameter int FRAC_BITS  = NIE_FRAC_BITS
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  req_t request,
	output logic empty,
	input  logic pop,
	output res_t result
);

	qctl_t qctl;
	cmd_t  cmd;
	logic  take;

	// Front end: request classification and queueing.
	nie_front u_front (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.full   (full),
		.request(request),
		.qctl   (qctl),
		.take   (take),
		.cmd    (cmd)
	);

	// Back end: stores, coefficient build, evaluation and the result register.
	nie_back #(
		.MAX_POINTS(MAX_POINTS),
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk   (clk),
		.arst_n(arst_n),
		.qctl  (qctl),
		.take  (take),
		.cmd   (cmd),
		.empty (empty),
		.pop   (pop),
		.result(result)
	);

endmodule

@@ rtl/nie_front.sv @@
// Front end: accepts requests, classifies them and holds them in a two-entry queue.
// Depends on nie_pkg.
`timescale 1ns / 1ps
module nie_front import nie_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	output logic  full,
	input  req_t  request,
	output qctl_t qctl,
	input  logic  take,
	output cmd_t  cmd
);

	localparam int DEPTH = 2;

	cmd_t       slot_q [DEPTH];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;
	cmd_t       incoming;
	logic       do_push;
	logic       do_take;

	always_comb begin
		incoming.x = request.point_x;
		incoming.y = request.point_y;
		incoming.t = request.query_point;
		if (request.action) begin
			incoming.op = OP_EVAL;
		end else if (request.first_point) begin
			incoming.op = OP_RESTART;
		end else begin
			incoming.op = OP_LOAD;
		end
	end

	assign full       = (count_q == 2'(DEPTH));
	assign do_push    = push && !full;
	assign qctl.valid = (count_q != 2'd0);
	assign qctl.take  = take && qctl.valid;
	assign do_take    = qctl.take;
	assign cmd        = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_ptr_q] <= incoming;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (do_push) wr_ptr_q <= ~wr_ptr_q;
			if (do_take) rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(do_push) - 2'(do_take);
		end
	end

endmodule

@@ rtl/nie_div.sv @@
// Iterative rounded fixed-point divider, one quotient bit per cycle.
// Depends on nie_pkg.
`timescale 1ns / 1ps
module nie_div import nie_pkg::*; #(
	parameter int FRAC_BITS = NIE_FRAC_BITS
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic signed [31:0] a,
	input  logic signed [31:0] b,
	output logic               done,
	output logic signed [31:0] quot,
	output logic               sat
);

	localparam int NW = 33 + FRAC_BITS;
	localparam int KW = $clog2(NW + 1);

	logic [NW-1:0] num_q;
	logic [NW-1:0] quo_q;
	logic [31:0]   rem_q;
	logic [31:0]   den_q;
	logic          neg_q;
	logic [KW-1:0] left_q;
	logic          busy_q;
	logic          done_q;
	logic [31:0]   abs_a;
	logic [31:0]   abs_b;
	logic [32:0]   rem_sh;
	logic          ge;
	logic          big;

	assign abs_a  = a[31] ? (32'd0 - a) : a;
	assign abs_b  = b[31] ? (32'd0 - b) : b;
	assign rem_sh = {rem_q, num_q[NW-1]};
	assign ge     = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= NW'({abs_a, {FRAC_BITS{1'b0}}}) + NW'(abs_b >> 1);
			den_q <= abs_b;
			neg_q <= a[31] ^ b[31];
			rem_q <= 32'd0;
			quo_q <= '0;
		end else if (busy_q) begin
			num_q <= {num_q[NW-2:0], 1'b0};
			rem_q <= ge ? 32'(rem_sh - {1'b0, den_q}) : rem_sh[31:0];
			quo_q <= {quo_q[NW-2:0], ge};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			left_q <= '0;
		end else begin
			done_q <= !start && busy_q && (left_q == KW'(1));
			if (start) begin
				busy_q <= 1'b1;
				left_q <= KW'(NW);
			end else if (busy_q) begin
				left_q <= left_q - 1'b1;
				if (left_q == KW'(1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_comb begin
		big = (quo_q[NW-1:31] != '0);
		if (!neg_q) begin
			sat  = big;
			quot = big ? Q_MAX : quo_q[31:0];
		end else begin
			sat  = big && (quo_q != NW'(64'h8000_0000));
			quot = sat ? Q_MIN : (32'd0 - quo_q[31:0]);
		end
	end

	assign done = done_q;

endmodule

@@ rtl/nie_back.sv @@
// Back end: point store, coefficient build and Horner evaluation sequencer.
// Depends on nie_pkg and nie_div.
`timescale 1ns / 1ps
module nie_back import nie_pkg::*; #(
	parameter int MAX_POINTS = NIE_MAX_POINTS,
	parameter int FRAC_BITS  = NIE_FRAC_BITS
) (
	input  logic  clk,
	input  logic  arst_n,
	input  qctl_t qctl,
	output logic  take,
	input  cmd_t  cmd,
	output logic  empty,
	input  logic  pop,
	output res_t  result
);

	localparam int IW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
	localparam int CW = $clog2(MAX_POINTS + 1);
	localparam logic signed [31:0] ONE = 32'(64'd1 << FRAC_BITS);

	state_t state_q, state_d;

	logic signed [31:0] xmem [MAX_POINTS];
	logic signed [31:0] cmem [MAX_POINTS];
	logic signed [31:0] x_rd_q, c_rd_q;

	cmd_t               cmd_q;
	logic [CW-1:0]      cnt_q;
	logic               ready_q, drop_q, dup_q, sat_q, esat_q, eval_mode_q;
	logic [IW-1:0]      bi_q, bj_q, hi_q;
	logic signed [31:0] xi_q, c_q, p_q, cj_q, r_q;
	logic signed [63:0] prod_q;
	logic               ov_q;
	res_t               res_q;

	// Sequencer outputs
	logic [IW-1:0]      x_raddr, c_raddr, x_waddr, c_waddr;
	logic               x_we, c_we;
	logic signed [31:0] x_wdata, c_wdata;
	logic               div_start;
	logic               div_done, div_sat;
	logic signed [31:0] div_q;

	logic [CW-1:0]      eff_cnt;
	logic               eff_ready;
	logic               more_builds;
	logic               slot_free;
	logic [32:0]        d_bld, d_ev, c0_sub, c_upd, acc, pfin, prfin;
	status_t            out_status;

	function automatic logic [32:0] qfin(logic signed [63:0] prod);
		logic signed [63:0] s;
		logic [32:0] r;
		s = (prod + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
		if (s > 64'(Q_MAX)) begin
			r = {1'b1, Q_MAX};
		end else if (s < 64'(Q_MIN)) begin
			r = {1'b1, Q_MIN};
		end else begin
			r = {1'b0, s[31:0]};
		end
		return r;
	endfunction

	assign eff_cnt     = (cmd_q.op == OP_RESTART) ? '0 : cnt_q;
	assign eff_ready   = (cmd_q.op == OP_RESTART) ? 1'b0 : ready_q;
	assign more_builds = ((CW'(bi_q) + CW'(1)) < cnt_q);
	assign slot_free   = !ov_q || pop;

	assign d_bld  = sat_addsub(xi_q, x_rd_q, 1'b1);
	assign d_ev   = sat_addsub(cmd_q.t, x_rd_q, 1'b1);
	assign c0_sub = sat_addsub(c_q, c_rd_q, 1'b1);
	assign pfin   = qfin(prod_q);
	assign c_upd  = sat_addsub(c_q, pfin[31:0], 1'b1);
	assign prfin  = qfin(prod_q);
	assign acc    = sat_addsub(prfin[31:0], cj_q, 1'b0);

	always_comb begin
		if (cnt_q == '0) begin
			out_status = ST_NO_POINTS;
		end else if (dup_q) begin
			out_status = ST_REPEATED;
		end else if (sat_q || esat_q) begin
			out_status = ST_SATURATED;
		end else if (drop_q) begin
			out_status = ST_DROPPED;
		end else begin
			out_status = ST_OK;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (qctl.valid) begin
					if (cmd.op == OP_EVAL) begin
						state_d = (!ready_q && cnt_q > CW'(1)) ? S_BLD_RDI : S_EV_CHK;
					end else begin
						state_d = S_LOAD;
					end
				end
			end
			S_LOAD: begin
				if (eff_cnt < CW'(MAX_POINTS) && eff_ready && eff_cnt != '0) begin
					state_d = S_BLD_RD0;
				end else begin
					state_d = S_IDLE;
				end
			end
			S_BLD_RDI: state_d = S_BLD_RD0;
			S_BLD_RD0: state_d = S_BLD_C0;
			S_BLD_C0:  state_d = S_BLD_RDJ;
			S_BLD_RDJ: state_d = S_BLD_D;
			S_BLD_D:   state_d = S_BLD_P;
			S_BLD_P:   state_d = (bj_q < bi_q) ? S_BLD_PC : S_BLD_DIV;
			S_BLD_PC:  state_d = S_BLD_C;
			S_BLD_C:   state_d = S_BLD_RDJ;
			S_BLD_DIV, S_BLD_WAIT: begin
				if (state_q == S_BLD_DIV && p_q != '0) begin
					state_d = S_BLD_WAIT;
				end else if (state_q == S_BLD_DIV || div_done) begin
					if (!eval_mode_q) begin
						state_d = S_IDLE;
					end else begin
						state_d = more_builds ? S_BLD_RDI : S_EV_CHK;
					end
				end
			end
			S_EV_CHK: state_d = (cnt_q == '0 || dup_q) ? S_EV_OUT : S_EV_RDN;
			S_EV_RDN: state_d = S_EV_R0;
			S_EV_R0:  state_d = (hi_q == '0) ? S_EV_OUT : S_EV_RD;
			S_EV_RD:  state_d = S_EV_MUL;
			S_EV_MUL: state_d = S_EV_ACC;
			S_EV_ACC: state_d = (hi_q == IW'(1)) ? S_EV_OUT : S_EV_RD;
			S_EV_OUT: state_d = slot_free ? S_IDLE : S_EV_OUT;
			default:  state_d = S_IDLE;
		endcase
	end

	// Sequencer outputs: store ports and divider start
	always_comb begin
		x_raddr   = '0;
		c_raddr   = '0;
		x_we      = 1'b0;
		c_we      = 1'b0;
		x_waddr   = eff_cnt[IW-1:0];
		c_waddr   = eff_cnt[IW-1:0];
		x_wdata   = cmd_q.x;
		c_wdata   = cmd_q.y;
		div_start = 1'b0;
		take      = 1'b0;
		unique case (state_q)
			S_IDLE: take = 1'b1;
			S_LOAD: begin
				x_we = (eff_cnt < CW'(MAX_POINTS));
				c_we = (eff_cnt < CW'(MAX_POINTS));
			end
			S_BLD_RDI: begin
				x_raddr = bi_q;
				c_raddr = bi_q;
			end
			S_BLD_RD0: c_raddr = '0;
			S_BLD_RDJ: begin
				x_raddr = bj_q - IW'(1);
				c_raddr = bj_q;
			end
			S_BLD_DIV: begin
				c_waddr = bi_q;
				if (p_q == '0) begin
					// Zero divisor: zero for a repeat or a zero numerator, else saturate.
					c_we = 1'b1;
					if (dup_q || c_q == '0) begin
						c_wdata = '0;
					end else begin
						c_wdata = c_q[31] ? Q_MIN : Q_MAX;
					end
				end else begin
					div_start = 1'b1;
				end
			end
			S_BLD_WAIT: begin
				c_waddr = bi_q;
				c_wdata = div_q;
				c_we    = div_done;
			end
			S_EV_RDN: c_raddr = IW'(cnt_q - CW'(1));
			S_EV_RD: begin
				x_raddr = hi_q - IW'(1);
				c_raddr = hi_q - IW'(1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (x_we) xmem[x_waddr] <= x_wdata;
		if (c_we) cmem[c_waddr] <= c_wdata;
		x_rd_q <= xmem[x_raddr];
		c_rd_q <= cmem[c_raddr];
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				if (qctl.valid) cmd_q <= cmd;
				bi_q <= IW'(1);
			end
			S_LOAD: begin
				bi_q <= eff_cnt[IW-1:0];
				xi_q <= cmd_q.x;
				c_q  <= cmd_q.y;
			end
			S_BLD_RD0: begin
				if (eval_mode_q) begin
					xi_q <= x_rd_q;
					c_q  <= c_rd_q;
				end
			end
			S_BLD_C0: begin
				c_q  <= c0_sub[31:0];
				p_q  <= ONE;
				bj_q <= IW'(1);
			end
			S_BLD_D: begin
				prod_q <= 64'(p_q) * 64'($signed(d_bld[31:0]));
				cj_q   <= c_rd_q;
			end
			S_BLD_P:  p_q <= pfin[31:0];
			S_BLD_PC: prod_q <= 64'(p_q) * 64'(cj_q);
			S_BLD_C: begin
				c_q  <= c_upd[31:0];
				bj_q <= bj_q + IW'(1);
			end
			S_BLD_DIV, S_BLD_WAIT: begin
				if ((state_q == S_BLD_DIV && p_q == '0) || div_done) begin
					bi_q <= bi_q + IW'(1);
				end
			end
			S_EV_CHK: begin
				hi_q <= IW'(cnt_q - CW'(1));
				r_q  <= '0;
			end
			S_EV_R0: r_q <= c_rd_q;
			S_EV_MUL: begin
				prod_q <= 64'(r_q) * 64'($signed(d_ev[31:0]));
				cj_q   <= c_rd_q;
			end
			S_EV_ACC: begin
				r_q  <= acc[31:0];
				hi_q <= hi_q - IW'(1);
			end
			S_EV_OUT: begin
				if (slot_free) begin
					res_q.value  <= r_q;
					res_q.status <= out_status;
				end
			end
			default: begin
			end
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			ready_q     <= 1'b0;
			drop_q      <= 1'b0;
			dup_q       <= 1'b0;
			sat_q       <= 1'b0;
			esat_q      <= 1'b0;
			eval_mode_q <= 1'b0;
			ov_q        <= 1'b0;
		end else begin
			state_q <= state_d;
			if (pop && ov_q && !(state_q == S_EV_OUT && slot_free)) ov_q <= 1'b0;
			unique case (state_q)
				S_IDLE: eval_mode_q <= (cmd.op == OP_EVAL);
				S_LOAD: begin
					if (cmd_q.op == OP_RESTART) begin
						ready_q <= 1'b0;
						dup_q   <= 1'b0;
						sat_q   <= 1'b0;
						drop_q  <= 1'b0;
					end
					if (eff_cnt >= CW'(MAX_POINTS)) begin
						drop_q <= 1'b1;
					end else begin
						cnt_q <= eff_cnt + CW'(1);
					end
				end
				S_BLD_C0: if (c0_sub[32]) sat_q <= 1'b1;
				S_BLD_D: begin
					if (xi_q == x_rd_q) dup_q <= 1'b1;
					if (d_bld[32]) sat_q <= 1'b1;
				end
				S_BLD_P: if (pfin[32]) sat_q <= 1'b1;
				S_BLD_C: if (pfin[32] || c_upd[32]) sat_q <= 1'b1;
				S_BLD_DIV: if (p_q == '0 && !dup_q && c_q != '0) sat_q <= 1'b1;
				S_BLD_WAIT: if (div_done && div_sat) sat_q <= 1'b1;
				S_EV_CHK: begin
					ready_q <= 1'b1;
					esat_q  <= 1'b0;
				end
				S_EV_MUL: if (d_ev[32]) esat_q <= 1'b1;
				S_EV_ACC: if (prfin[32] || acc[32]) esat_q <= 1'b1;
				S_EV_OUT: if (slot_free) ov_q <= 1'b1;
				default: begin
				end
			endcase
		end
	end

	nie_div #(
		.FRAC_BITS(FRAC_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (div_start),
		.a     (c_q),
		.b     (p_q),
		.done  (div_done),
		.quot  (div_q),
		.sat   (div_sat)
	);

	assign empty  = !ov_q;
	assign result = res_q;

endmodule
